// File: rtl/hsv2rgb_pkg.sv
// hsv2rgb_pkg: types and constants shared by the hsv to rgb converter
// no dependencies; used by hsv2rgb_core and hsv_to_rgb_converter
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    localparam logic [14:0] HUE_SECTOR = 15'd3840;
    localparam logic [14:0] HUE_PAIR   = 15'd7680;
    localparam logic [14:0] HUE_TURN   = 15'd23040;
    localparam logic [15:0] Q_ONE      = 16'd32768;

    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW   = 3'd0,
        SECTOR_YELLOW_GREEN = 3'd1,
        SECTOR_GREEN_CYAN   = 3'd2,
        SECTOR_CYAN_BLUE    = 3'd3,
        SECTOR_BLUE_MAGENTA = 3'd4,
        SECTOR_MAGENTA_RED  = 3'd5
    } sector_t;

    typedef struct packed {
        logic [14:0] hue;
        logic [15:0] saturation;
        logic [15:0] brightness;
    } hsv_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        sector_t    sector;
        logic [7:0] c_byte;
        logic [7:0] z_byte;
        logic [7:0] x_byte;
    } comp_t;

endpackage

// File: rtl/hsv2rgb_core.sv
// hsv2rgb_core: four-stage arithmetic pipeline producing the three component bytes
// depends on hsv2rgb_pkg
`timescale 1ns / 1ps

module hsv2rgb_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic [14:0]          hue,
    input  logic [15:0]          sat,
    input  logic [15:0]          val,
    output logic                 comp_valid,
    output hsv2rgb_pkg::comp_t   comp
);

    // stage 1: sector, triangle distance, v * s
    logic                 valid1_reg;
    hsv2rgb_pkg::sector_t sector1_reg, sector1_next;
    logic [11:0]          t1_reg, t1_next;
    logic [30:0]          vs1_reg;
    logic [15:0]          v1_reg;
    logic [14:0]          pair_base;
    logic [12:0]          f_pos;
    logic [31:0]          vs_full;

    // stage 2: vs * t and the zero-component numerator
    logic                 valid2_reg;
    hsv2rgb_pkg::sector_t sector2_reg;
    logic [42:0]          p2_reg, p2_next;
    logic [30:0]          mz2_reg, mz2_next;
    logic [15:0]          v2_reg;

    // stage 3: secondary numerator, zero and chroma bytes
    logic                 valid3_reg;
    hsv2rgb_pkg::sector_t sector3_reg;
    logic [41:0]          d3_reg, d3_next;
    logic [7:0]           z3_reg, c3_reg;
    logic [27:0]          v_sec;
    logic [42:0]          v_shift;
    logic [42:0]          d_full;
    logic [38:0]          z_sum;
    logic [23:0]          c_sum;

    // stage 4: secondary byte
    logic                 valid4_reg;
    hsv2rgb_pkg::comp_t   comp4_reg;
    logic [47:0]          x_sum;

    always_comb
    begin
        priority if (hue < hsv2rgb_pkg::HUE_SECTOR)
        begin
            sector1_next = hsv2rgb_pkg::SECTOR_RED_YELLOW;
        end
        else if (hue < 15'(2 * hsv2rgb_pkg::HUE_SECTOR))
        begin
            sector1_next = hsv2rgb_pkg::SECTOR_YELLOW_GREEN;
        end
        else if (hue < 15'(3 * hsv2rgb_pkg::HUE_SECTOR))
        begin
            sector1_next = hsv2rgb_pkg::SECTOR_GREEN_CYAN;
        end
        else if (hue < 15'(4 * hsv2rgb_pkg::HUE_SECTOR))
        begin
            sector1_next = hsv2rgb_pkg::SECTOR_CYAN_BLUE;
        end
        else if (hue < 15'(5 * hsv2rgb_pkg::HUE_SECTOR))
        begin
            sector1_next = hsv2rgb_pkg::SECTOR_BLUE_MAGENTA;
        end
        else
        begin
            sector1_next = hsv2rgb_pkg::SECTOR_MAGENTA_RED;
        end

        unique case (sector1_next)
            hsv2rgb_pkg::SECTOR_RED_YELLOW,
            hsv2rgb_pkg::SECTOR_YELLOW_GREEN:
                pair_base = 15'd0;
            hsv2rgb_pkg::SECTOR_GREEN_CYAN,
            hsv2rgb_pkg::SECTOR_CYAN_BLUE:
                pair_base = hsv2rgb_pkg::HUE_PAIR;
            default:
                pair_base = 15'(2 * hsv2rgb_pkg::HUE_PAIR);
        endcase

        f_pos = 13'(hue - pair_base);
        if (f_pos >= 13'(hsv2rgb_pkg::HUE_SECTOR))
        begin
            t1_next = 12'(f_pos - 13'(hsv2rgb_pkg::HUE_SECTOR));
        end
        else
        begin
            t1_next = 12'(13'(hsv2rgb_pkg::HUE_SECTOR) - f_pos);
        end

        vs_full = val * sat;
    end

    always_comb
    begin
        p2_next  = 43'(vs1_reg) * 43'(t1_reg);
        mz2_next = {v1_reg[15:0], 15'b0} - vs1_reg;
    end

    always_comb
    begin
        v_sec   = 28'(v2_reg) * 28'(hsv2rgb_pkg::HUE_SECTOR);
        v_shift = {v_sec, 15'b0};
        d_full  = v_shift - p2_reg;
        d3_next = d_full[41:0];
        z_sum   = {mz2_reg, 8'b0} - {8'b0, mz2_reg} + 39'd536870912;
        c_sum   = {v2_reg, 8'b0} - {8'b0, v2_reg} + 24'd16384;
    end

    always_comb
    begin
        x_sum = {2'b0, d3_reg, 4'b0} + {6'b0, d3_reg} + 48'd137438953472;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= item_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            valid4_reg <= valid3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sector1_reg <= sector1_next;
        t1_reg      <= t1_next;
        vs1_reg     <= vs_full[30:0];
        v1_reg      <= val;

        sector2_reg <= sector1_reg;
        p2_reg      <= p2_next;
        mz2_reg     <= mz2_next;
        v2_reg      <= v1_reg;

        sector3_reg <= sector2_reg;
        d3_reg      <= d3_next;
        z3_reg      <= z_sum[37:30];
        c3_reg      <= c_sum[22:15];

        comp4_reg.sector <= sector3_reg;
        comp4_reg.c_byte <= c3_reg;
        comp4_reg.z_byte <= z3_reg;
        comp4_reg.x_byte <= x_sum[45:38];
    end

    assign comp_valid = valid4_reg;
    assign comp       = comp4_reg;

endmodule

// File: rtl/hsv_to_rgb_converter.sv
// hsv_to_rgb_converter: top level, input conditioning, core pipeline and rgb output
// depends on hsv2rgb_pkg and hsv2rgb_core
`timescale 1ns / 1ps

// Converts one hsv color to 8-bit rgb per item.
// Input channel: hsv (hue in 1/64 degree, saturation and brightness in Q1.15)
// is taken at a rising edge where start is high and busy is low. busy is
// always low, so a new item may be presented on every cycle.
// Output channel: rgb is valid for exactly one cycle while done is high;
// the item is taken at the edge that ends that cycle. The receiver cannot
// stall, and none is needed since nothing is ever held back.
// Path: an input register, four arithmetic stages and an output register
// lie between the accepting edge and done. Throughput is one item per
// clock, set by the fully pipelined datapath; the widest step is the
// 31 x 12 multiply in the second arithmetic stage.
// Items leave in the order they enter, one result for each.
// Reset (rst_n low, asynchronous) clears all valid bits, so no stray done
// follows reset; data registers are not reset.
// Hue at or past a full turn wraps once; saturation and brightness above
// one are held at one.

module hsv_to_rgb_converter
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  hsv2rgb_pkg::hsv_t   hsv,
    output logic                done,
    output hsv2rgb_pkg::rgb_t   rgb
);

    logic               valid0_reg;
    logic [14:0]        h0_reg, h0_next;
    logic [15:0]        s0_reg, s0_next;
    logic [15:0]        v0_reg, v0_next;
    logic               core_valid;
    hsv2rgb_pkg::comp_t core_comp;
    logic               done_reg;
    hsv2rgb_pkg::rgb_t  rgb_reg, rgb_next;

    assign busy = 1'b0;

    always_comb
    begin
        if (hsv.hue >= hsv2rgb_pkg::HUE_TURN)
        begin
            h0_next = hsv.hue - hsv2rgb_pkg::HUE_TURN;
        end
        else
        begin
            h0_next = hsv.hue;
        end
        s0_next = (hsv.saturation > hsv2rgb_pkg::Q_ONE) ? hsv2rgb_pkg::Q_ONE : hsv.saturation;
        v0_next = (hsv.brightness > hsv2rgb_pkg::Q_ONE) ? hsv2rgb_pkg::Q_ONE : hsv.brightness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid0_reg <= start & ~busy;
            done_reg   <= core_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        h0_reg  <= h0_next;
        s0_reg  <= s0_next;
        v0_reg  <= v0_next;
        rgb_reg <= rgb_next;
    end

    hsv2rgb_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (valid0_reg),
        .hue        (h0_reg),
        .sat        (s0_reg),
        .val        (v0_reg),
        .comp_valid (core_valid),
        .comp       (core_comp)
    );

    // place chroma, secondary and zero components by sector
    always_comb
    begin
        unique case (core_comp.sector)
            hsv2rgb_pkg::SECTOR_RED_YELLOW:
            begin
                rgb_next = '{red: core_comp.c_byte, green: core_comp.x_byte,
                             blue: core_comp.z_byte};
            end
            hsv2rgb_pkg::SECTOR_YELLOW_GREEN:
            begin
                rgb_next = '{red: core_comp.x_byte, green: core_comp.c_byte,
                             blue: core_comp.z_byte};
            end
            hsv2rgb_pkg::SECTOR_GREEN_CYAN:
            begin
                rgb_next = '{red: core_comp.z_byte, green: core_comp.c_byte,
                             blue: core_comp.x_byte};
            end
            hsv2rgb_pkg::SECTOR_CYAN_BLUE:
            begin
                rgb_next = '{red: core_comp.z_byte, green: core_comp.x_byte,
                             blue: core_comp.c_byte};
            end
            hsv2rgb_pkg::SECTOR_BLUE_MAGENTA:
            begin
                rgb_next = '{red: core_comp.x_byte, green: core_comp.z_byte,
                             blue: core_comp.c_byte};
            end
            default:
            begin
                rgb_next = '{red: core_comp.c_byte, green: core_comp.z_byte,
                             blue: core_comp.x_byte};
            end
        endcase
    end

    assign done = done_reg;
    assign rgb  = rgb_reg;

endmodule

// File: bench/hsv_to_rgb_converter_tb.sv
// hsv_to_rgb_converter_tb: self-checking bench for the hsv to rgb converter
// predicts every rgb result in exact integer math; depends on hsv2rgb_pkg
// and the hsv_to_rgb_converter rtl
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;

    import hsv2rgb_pkg::*;

    localparam int N_RANDOM    = 900;
    localparam int DRAIN       = 12;
    localparam int CYCLE_LIMIT = 200000;

    class rgb_expect_book;
        rgb_t expected_q[$];
        int   mismatches;
        int   checked;
        int   noted;
        int   clipped_inputs;

        function new();
            mismatches     = 0;
            checked        = 0;
            noted          = 0;
            clipped_inputs = 0;
        endfunction

        function logic [7:0] scale_to_byte(logic [63:0] num, logic [63:0] den);
            logic [63:0] q;
            q = (num * 64'd255 + den / 64'd2) / den;
            return (q > 64'd255) ? 8'hFF : q[7:0];
        endfunction

        function rgb_t hsv_to_rgb(hsv_t px);
            logic [14:0] h;
            logic [63:0] s, v, f, t, vs, c, x, m, den, r1, g1, b1;
            sector_t     sec;
            rgb_t        res;
            h = px.hue;
            if (h >= HUE_TURN)
            begin
                h = h - HUE_TURN;
            end
            s   = (px.saturation > Q_ONE) ? 64'(Q_ONE) : 64'(px.saturation);
            v   = (px.brightness > Q_ONE) ? 64'(Q_ONE) : 64'(px.brightness);
            sec = sector_t'(3'(h / HUE_SECTOR));
            f   = 64'(h % HUE_PAIR);
            t   = (f >= 64'(HUE_SECTOR)) ? f - 64'(HUE_SECTOR) : 64'(HUE_SECTOR) - f;
            den = 64'(HUE_SECTOR) << 30;
            vs  = v * s;
            c   = vs * 64'(HUE_SECTOR);
            x   = vs * (64'(HUE_SECTOR) - t);
            m   = v * 64'(Q_ONE) * 64'(HUE_SECTOR) - c;
            r1  = '0;
            g1  = '0;
            b1  = '0;
            case (sec)
                SECTOR_RED_YELLOW:   begin r1 = c; g1 = x; end
                SECTOR_YELLOW_GREEN: begin r1 = x; g1 = c; end
                SECTOR_GREEN_CYAN:   begin g1 = c; b1 = x; end
                SECTOR_CYAN_BLUE:    begin g1 = x; b1 = c; end
                SECTOR_BLUE_MAGENTA: begin r1 = x; b1 = c; end
                default:             begin r1 = c; b1 = x; end
            endcase
            res.red   = scale_to_byte(r1 + m, den);
            res.green = scale_to_byte(g1 + m, den);
            res.blue  = scale_to_byte(b1 + m, den);
            return res;
        endfunction

        function void note_input(hsv_t px);
            noted++;
            if (px.hue >= HUE_TURN || px.saturation > Q_ONE || px.brightness > Q_ONE)
            begin
                clipped_inputs++;
            end
            expected_q.push_back(hsv_to_rgb(px));
        endfunction

        function void check_result(rgb_t got);
            rgb_t want;
            if (expected_q.size() == 0)
            begin
                $error("rgb result %h with no item pending", got);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.red !== want.red)
            begin
                $error("red: expected %0d, got %0d", want.red, got.red);
                mismatches++;
            end
            if (got.green !== want.green)
            begin
                $error("green: expected %0d, got %0d", want.green, got.green);
                mismatches++;
            end
            if (got.blue !== want.blue)
            begin
                $error("blue: expected %0d, got %0d", want.blue, got.blue);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    hsv_t hsv;
    logic done;
    rgb_t rgb;

    rgb_expect_book book = new();
    int             cycle_count = 0;

    hsv_to_rgb_converter i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .hsv   (hsv),
        .done  (done),
        .rgb   (rgb)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // accepted items and results, sampled with pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            book.note_input(hsv);
        end
        if (rst_n && done)
        begin
            book.check_result(rgb);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     book.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_hsv(input hsv_t px);
        start <= 1'b1;
        hsv   <= px;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic hsv_t make_hsv(int h, int s, int v);
        hsv_t px;
        px.hue        = 15'(h);
        px.saturation = 16'(s);
        px.brightness = 16'(v);
        return px;
    endfunction

    // mostly in-range colors, some sector edges, some out-of-range fields
    function automatic hsv_t random_hsv();
        hsv_t px;
        int   pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            px.hue = 15'($urandom_range(0, 23039));
        else if (pick < 9)
            px.hue = 15'($urandom_range(0, 6) * 3840 + $urandom_range(0, 2) - 1);
        else
            px.hue = 15'($urandom_range(0, 32767));
        pick = $urandom_range(0, 9);
        if (pick < 7)
            px.saturation = 16'($urandom_range(0, 32768));
        else if (pick < 9)
            px.saturation = ($urandom_range(0, 1) == 0) ? 16'd0 : Q_ONE;
        else
            px.saturation = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 9);
        if (pick < 7)
            px.brightness = 16'($urandom_range(0, 32768));
        else if (pick < 9)
            px.brightness = ($urandom_range(0, 1) == 0) ? 16'd0 : Q_ONE;
        else
            px.brightness = 16'($urandom_range(0, 65535));
        return px;
    endfunction

    initial
    begin
        hsv_t directed_q[$];
        int   sent;
        int   burst;

        rst_n <= 1'b0;
        start <= 1'b0;
        hsv   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_q = '{
            make_hsv(0, 0, 0),
            make_hsv(0, 32768, 32768),
            make_hsv(3840, 32768, 32768),
            make_hsv(7680, 32768, 32768),
            make_hsv(11520, 32768, 32768),
            make_hsv(15360, 32768, 32768),
            make_hsv(19200, 32768, 32768),
            make_hsv(3839, 32768, 32768),
            make_hsv(7679, 32768, 32768),
            make_hsv(23039, 32768, 32768),
            make_hsv(23040, 32768, 32768),
            make_hsv(32767, 65535, 65535),
            make_hsv(1920, 16384, 16384),
            make_hsv(9600, 0, 32768),
            make_hsv(13440, 32768, 0),
            make_hsv(17280, 32769, 32768),
            make_hsv(21120, 32768, 32769),
            make_hsv(5760, 1, 1),
            make_hsv(26880, 24576, 49152),
            make_hsv(1, 32767, 32767),
            make_hsv(21845, 43690, 21845),
            make_hsv(10922, 21845, 43690)
        };
        foreach (directed_q[i])
        begin
            send_hsv(directed_q[i]);
        end
        idle_cycles(3);

        sent = 0;
        while (sent < N_RANDOM)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < N_RANDOM; k++)
            begin
                send_hsv(random_hsv());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                idle_cycles($urandom_range(1, 7));
            end
        end
        start <= 1'b0;

        while (book.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);

        $display("%0d hsv items sent (%0d directed), %0d rgb results checked",
                 book.noted, directed_q.size(), book.checked);
        $display("%0d items had hue past a full turn or saturation/brightness above one",
                 book.clipped_inputs);
        if (book.mismatches == 0 && book.pending() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
